### src/i2csrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2csrb_pkg: shared types and constants
// Bus event codes, side-effect codes, the fixed register map and the result
// record passed from the register core to the output stage.
// ----------------------------------------------------------------------------
package i2csrb_pkg;

  // Bus event codes
  typedef enum logic [1:0] {
    CMD_START_STOP = 2'd0,
    CMD_RX_BYTE    = 2'd1,
    CMD_READ       = 2'd2,
    CMD_NACK       = 2'd3
  } cmd_e;

  // Side effect reported with a register write
  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_POWER    = 3'd1,
    ACT_PWM      = 3'd2,
    ACT_LCD_RST  = 3'd3,
    ACT_TP_RST   = 3'd4
  } action_e;

  // Register map (fixed)
  localparam logic [4:0] ADDR_ID          = 5'd0;
  localparam logic [4:0] ADDR_PORT_MIRROR = 5'd2;
  localparam logic [4:0] ADDR_POWER       = 5'd5;
  localparam logic [4:0] ADDR_PWM         = 5'd6;
  localparam logic [4:0] ADDR_LCD_RESET   = 5'd19;
  localparam logic [4:0] ADDR_TOUCH_RESET = 5'd20;
  localparam logic [4:0] ADDR_TOUCH_STAT  = 5'd21;
  localparam logic [4:0] ADDR_TOUCH_XY    = 5'd22;

  localparam logic [7:0] ID_DEFAULT    = 8'hC3;

  // Receive byte counter values within one transfer
  localparam logic [1:0] RX_NONE       = 2'd0;
  localparam logic [1:0] RX_POINTER    = 2'd1;
  localparam logic [1:0] RX_DATA       = 2'd2;

  typedef struct packed {
    logic       read_valid;
    logic [7:0] read_byte;
    action_e    action;
    logic [7:0] action_value;
    logic [7:0] power_level;
    logic [7:0] pwm_level;
    logic [7:0] lcd_reset_level;
    logic [7:0] touch_reset_level;
  } result_t;

endpackage

### src/i2csrb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2csrb channel interfaces
// Valid/ready channels for bus events, configuration writes and results.
// ----------------------------------------------------------------------------
interface i2csrb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface i2csrb_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface i2csrb_out_if;
  logic       valid;
  logic       ready;
  logic       read_valid;
  logic [7:0] read_byte;
  logic [2:0] action;
  logic [7:0] action_value;
  logic [7:0] power_level;
  logic [7:0] pwm_level;
  logic [7:0] lcd_reset_level;
  logic [7:0] touch_reset_level;

  modport source (
    output valid, output read_valid, output read_byte, output action,
    output action_value, output power_level, output pwm_level,
    output lcd_reset_level, output touch_reset_level, input ready
  );
  modport sink (
    input valid, input read_valid, input read_byte, input action,
    input action_value, input power_level, input pwm_level,
    input lcd_reset_level, input touch_reset_level, output ready
  );
endinterface

### src/i2csrb_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2csrb_core: register bank state and event decode
// Holds the register file, pointer, receive count and transmit state, and
// forms the result record of the event being transferred.
// ----------------------------------------------------------------------------
module i2csrb_core #(
  parameter int NUM_REGS = 23,
  parameter int TX_DEPTH = 42
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                ev_fire_i,
  input  logic [1:0]          command_i,
  input  logic [7:0]          data_byte_i,
  input  logic                cfg_fire_i,
  input  logic [7:0]          cfg_data_i,
  output i2csrb_pkg::result_t result_o
);

  localparam int PW    = $clog2(NUM_REGS + 1);
  localparam int IDX_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam logic [PW-1:0]    PTR_NONE = PW'(NUM_REGS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TX_DEPTH - 1);

  logic [7:0]       regs_q [NUM_REGS];
  logic [7:0]       regs_d [NUM_REGS];
  logic [PW-1:0]    ptr_q, ptr_d;
  logic [1:0]       rx_cnt_q, rx_cnt_d;
  // Only the first buffer byte is ever loaded; the rest stay at zero.
  logic [7:0]       tx0_q, tx0_d;
  logic [IDX_W-1:0] tx_idx_q, tx_idx_d;

  logic             ptr_ok;
  logic             wr_ok;
  logic [7:0]       sel_byte;

  always_comb begin
    regs_d     = regs_q;
    ptr_d      = ptr_q;
    rx_cnt_d   = rx_cnt_q;
    tx0_d      = tx0_q;
    tx_idx_d   = tx_idx_q;
    ptr_ok     = 1'b0;
    wr_ok      = 1'b0;
    sel_byte   = 8'h00;
    result_o.read_valid   = 1'b0;
    result_o.read_byte    = 8'h00;
    result_o.action       = i2csrb_pkg::ACT_NONE;
    result_o.action_value = 8'h00;

    case (i2csrb_pkg::cmd_e'(command_i))
      i2csrb_pkg::CMD_START_STOP: begin
        rx_cnt_d = i2csrb_pkg::RX_NONE;
      end
      i2csrb_pkg::CMD_RX_BYTE: begin
        if (rx_cnt_q != i2csrb_pkg::RX_POINTER) begin
          // pointer byte (first of a transfer, or one that follows a data byte)
          rx_cnt_d = i2csrb_pkg::RX_POINTER;
          if (data_byte_i[7]) begin
            ptr_d = (data_byte_i[6:0] < 7'(NUM_REGS)) ? data_byte_i[PW-1:0] : PTR_NONE;
          end
          ptr_ok = (ptr_d < PTR_NONE);
          if (ptr_ok) begin
            sel_byte = regs_q[ptr_d];
            tx_idx_d = '0;
            if (ptr_d != PW'(i2csrb_pkg::ADDR_TOUCH_STAT) &&
                ptr_d != PW'(i2csrb_pkg::ADDR_TOUCH_XY)) begin
              tx0_d = sel_byte;
            end
          end
        end else begin
          // data byte
          rx_cnt_d = i2csrb_pkg::RX_DATA;
          wr_ok = (ptr_q < PTR_NONE) &&
                  (ptr_q != PW'(i2csrb_pkg::ADDR_ID)) &&
                  (ptr_q != PW'(i2csrb_pkg::ADDR_PORT_MIRROR)) &&
                  (ptr_q != PW'(i2csrb_pkg::ADDR_TOUCH_STAT)) &&
                  (ptr_q != PW'(i2csrb_pkg::ADDR_TOUCH_XY));
          if (wr_ok) begin
            regs_d[ptr_q] = data_byte_i;
            tx_idx_d      = '0;
            tx0_d         = data_byte_i;
            if (ptr_q == PW'(i2csrb_pkg::ADDR_POWER)) begin
              regs_d[i2csrb_pkg::ADDR_PORT_MIRROR] = data_byte_i;
              result_o.action = i2csrb_pkg::ACT_POWER;
            end else if (ptr_q == PW'(i2csrb_pkg::ADDR_PWM)) begin
              result_o.action = i2csrb_pkg::ACT_PWM;
            end else if (ptr_q == PW'(i2csrb_pkg::ADDR_LCD_RESET)) begin
              result_o.action = i2csrb_pkg::ACT_LCD_RST;
            end else if (ptr_q == PW'(i2csrb_pkg::ADDR_TOUCH_RESET)) begin
              result_o.action = i2csrb_pkg::ACT_TP_RST;
            end
            if (result_o.action != i2csrb_pkg::ACT_NONE) begin
              result_o.action_value = data_byte_i;
            end
          end
        end
      end
      i2csrb_pkg::CMD_READ: begin
        result_o.read_valid = 1'b1;
        result_o.read_byte  = (tx_idx_q == '0) ? tx0_q : 8'h00;
        tx_idx_d = (tx_idx_q == IDX_LAST) ? '0 : tx_idx_q + 1'b1;
      end
      default: begin
      end
    endcase

    result_o.power_level       = regs_d[i2csrb_pkg::ADDR_POWER];
    result_o.pwm_level         = regs_d[i2csrb_pkg::ADDR_PWM];
    result_o.lcd_reset_level   = regs_d[i2csrb_pkg::ADDR_LCD_RESET];
    result_o.touch_reset_level = regs_d[i2csrb_pkg::ADDR_TOUCH_RESET];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_q[i] <= (i == int'(i2csrb_pkg::ADDR_ID)) ? i2csrb_pkg::ID_DEFAULT : 8'h00;
      end
      ptr_q    <= PTR_NONE;
      rx_cnt_q <= i2csrb_pkg::RX_NONE;
      tx0_q    <= 8'h00;
      tx_idx_q <= '0;
    end else begin
      // ID register is only ever written from the config port
      for (int i = 0; i < NUM_REGS; i++) begin
        if (cfg_fire_i && (i == int'(i2csrb_pkg::ADDR_ID))) begin
          regs_q[i] <= cfg_data_i;
        end else if (ev_fire_i) begin
          regs_q[i] <= regs_d[i];
        end
      end
      if (ev_fire_i) begin
        ptr_q    <= ptr_d;
        rx_cnt_q <= rx_cnt_d;
        tx0_q    <= tx0_d;
        tx_idx_q <= tx_idx_d;
      end
    end
  end

  a_rx_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_cnt_q != 2'd3) else $error("receive count out of range");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= PTR_NONE) else $error("pointer beyond bank");

  a_tx_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_idx_q <= IDX_LAST) else $error("transmit index beyond buffer");

  a_portb_mirror: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_fire_i && result_o.action == i2csrb_pkg::ACT_POWER |=>
      regs_q[i2csrb_pkg::ADDR_PORT_MIRROR] == regs_q[i2csrb_pkg::ADDR_POWER])
    else $error("port-B mirror not updated by power write");

endmodule

### src/i2csrb_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2csrb_out_stage: result register
// Holds one result until the sink takes it; passes a new one in the same
// cycle that the held one is transferred.
// ----------------------------------------------------------------------------
module i2csrb_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  i2csrb_pkg::result_t result_i,
  output logic                can_load_o,
  output logic                valid_o,
  input  logic                ready_i,
  output i2csrb_pkg::result_t result_o
);

  logic                valid_q;
  i2csrb_pkg::result_t res_q;

  assign can_load_o = !valid_q || ready_i;
  assign valid_o    = valid_q;
  assign result_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_load_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && can_load_o) begin
      res_q <= result_i;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !ready_i |=> valid_q && $stable(res_q))
    else $error("held result lost");

  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i && can_load_o |=> valid_q)
    else $error("loaded result not shown");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && ready_i && !load_i |=> !valid_q)
    else $error("transferred result repeated");

endmodule

### src/i2c_slave_register_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_slave_register_bank: byte-level I2C slave register bank
// An event's result is registered and shows on out_o in the next cycle.
// Throughput: one bus event per cycle unless out_o stalls; the result register
//   frees on transfer of its result, so events and results stream back to back.
// Reset (rst_ni low, async): ID register to 0xC3, other registers zero,
//   no register selected, counts and transmit byte cleared, no result held.
// ----------------------------------------------------------------------------
module i2c_slave_register_bank #(
  parameter int NUM_REGS = 23,
  parameter int TX_DEPTH = 42
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  i2csrb_in_if.sink     in_i,
  i2csrb_cfg_if.sink    cfg_i,
  i2csrb_out_if.source  out_o
);

  // Event decode and state in the core; the state moves on each event
  // transfer and the matching result goes into the output register.
  i2csrb_pkg::result_t core_res;
  i2csrb_pkg::result_t out_res;
  logic                ev_ready;
  logic                ev_fire;

  assign in_i.ready  = ev_ready;
  assign ev_fire     = in_i.valid && ev_ready;

  // Configuration writes are always taken; they only touch the ID register.
  assign cfg_i.ready = 1'b1;

  i2csrb_core #(
    .NUM_REGS (NUM_REGS),
    .TX_DEPTH (TX_DEPTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ev_fire_i   (ev_fire),
    .command_i   (in_i.command),
    .data_byte_i (in_i.data_byte),
    .cfg_fire_i  (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .result_o    (core_res)
  );

  // One result per event, held until the sink takes it.
  i2csrb_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (in_i.valid),
    .result_i   (core_res),
    .can_load_o (ev_ready),
    .valid_o    (out_o.valid),
    .ready_i    (out_o.ready),
    .result_o   (out_res)
  );

  assign out_o.read_valid        = out_res.read_valid;
  assign out_o.read_byte         = out_res.read_byte;
  assign out_o.action            = out_res.action;
  assign out_o.action_value      = out_res.action_value;
  assign out_o.power_level       = out_res.power_level;
  assign out_o.pwm_level         = out_res.pwm_level;
  assign out_o.lcd_reset_level   = out_res.lcd_reset_level;
  assign out_o.touch_reset_level = out_res.touch_reset_level;

endmodule

### dv/i2c_slave_register_bank_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_slave_register_bank_tb: self-checking bench for the I2C register bank
// Drives bus events through the valid/ready event channel and mirrors the
// bank in a local model: register file, selection, receive count and the
// wrapping transmit buffer. Every result transfer is checked field by field
// against the oldest outstanding prediction. Directed sequences come first,
// then well-formed random transfers mixed with noise. Both channel ends idle
// at random, and the ID register is reprogrammed between phases.
// ----------------------------------------------------------------------------
module i2c_slave_register_bank_tb;

  localparam int         NUM_REGS       = 23;
  localparam int         TX_DEPTH       = 42;
  localparam logic [7:0] PTR_BASE       = 8'h80;  // pointer bytes from here select
  localparam int         RX_HOLD_CYCLES = 48;     // long receiver hold-off

  logic clk_i;
  logic rst_ni;

  i2csrb_in_if  ev_if ();
  i2csrb_cfg_if cfg_if ();
  i2csrb_out_if res_if ();

  i2c_slave_register_bank #(
    .NUM_REGS(NUM_REGS),
    .TX_DEPTH(TX_DEPTH)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (ev_if),
    .cfg_i (cfg_if),
    .out_o (res_if)
  );

  // 2 ns period
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Local copy of the bank state
  // --------------------------------------------------------------------------
  logic [7:0] bank_regs [NUM_REGS];
  logic [4:0] sel_ptr;          // NUM_REGS means nothing selected
  logic [1:0] rx_count;
  logic [7:0] last_ptr_byte;
  logic [7:0] tx_buf [TX_DEPTH];
  int         tx_idx;

  i2csrb_pkg::result_t pending_replies[$];  // predicted results, oldest first
  i2csrb_pkg::result_t oldest_reply;
  int         fail_cnt;
  int         sent_cnt;             // accepted bus events
  int         burst_left;
  bit         steady_tx;            // sender offers back to back when set
  bit         hold_req;             // asks the receiver for a long hold-off

  // Outcome of one bus event; updates the local bank as a side effect
  function automatic i2csrb_pkg::result_t bus_event_outcome(i2csrb_pkg::cmd_e cmd,
                                                            logic [7:0] b);
    i2csrb_pkg::result_t r;
    int      off;
    r = '0;
    case (cmd)
      i2csrb_pkg::CMD_START_STOP: rx_count = i2csrb_pkg::RX_NONE;
      i2csrb_pkg::CMD_RX_BYTE: begin
        // a third byte in one transfer starts over as a pointer byte
        if (rx_count == i2csrb_pkg::RX_DATA) rx_count = i2csrb_pkg::RX_NONE;
        if (rx_count == i2csrb_pkg::RX_NONE) begin
          last_ptr_byte = b;
          rx_count      = i2csrb_pkg::RX_POINTER;
          if (b >= PTR_BASE) begin
            off     = b - PTR_BASE;
            sel_ptr = (off < NUM_REGS) ? 5'(off) : 5'(NUM_REGS);
          end
          // below the base the old selection stays and still rewinds
          if (sel_ptr < NUM_REGS) begin
            tx_idx = 0;
            // touch registers leave stale bytes in the buffer
            if (!(sel_ptr inside {i2csrb_pkg::ADDR_TOUCH_STAT, i2csrb_pkg::ADDR_TOUCH_XY}))
              tx_buf[0] = bank_regs[sel_ptr];
          end
        end else begin
          rx_count = i2csrb_pkg::RX_DATA;
          if (sel_ptr < NUM_REGS &&
              !(sel_ptr inside {i2csrb_pkg::ADDR_ID, i2csrb_pkg::ADDR_PORT_MIRROR,
                                i2csrb_pkg::ADDR_TOUCH_STAT,
                                i2csrb_pkg::ADDR_TOUCH_XY})) begin
            bank_regs[sel_ptr] = b;
            tx_idx             = 0;
            tx_buf[0]          = b;
            case (sel_ptr)
              i2csrb_pkg::ADDR_POWER: begin
                bank_regs[i2csrb_pkg::ADDR_PORT_MIRROR] = b;  // port-B mirrors power
                r.action = i2csrb_pkg::ACT_POWER;
              end
              i2csrb_pkg::ADDR_PWM:         r.action = i2csrb_pkg::ACT_PWM;
              i2csrb_pkg::ADDR_LCD_RESET:   r.action = i2csrb_pkg::ACT_LCD_RST;
              i2csrb_pkg::ADDR_TOUCH_RESET: r.action = i2csrb_pkg::ACT_TP_RST;
              default: ;
            endcase
            if (r.action != i2csrb_pkg::ACT_NONE) r.action_value = b;
          end
        end
      end
      i2csrb_pkg::CMD_READ: begin
        if (tx_idx >= TX_DEPTH) tx_idx = 0;
        r.read_valid = 1'b1;
        r.read_byte  = tx_buf[tx_idx];
        tx_idx++;
        if (tx_idx >= TX_DEPTH) tx_idx = 0;
      end
      default: ;  // nack: nothing moves
    endcase
    r.power_level       = bank_regs[i2csrb_pkg::ADDR_POWER];
    r.pwm_level         = bank_regs[i2csrb_pkg::ADDR_PWM];
    r.lcd_reset_level   = bank_regs[i2csrb_pkg::ADDR_LCD_RESET];
    r.touch_reset_level = bank_regs[i2csrb_pkg::ADDR_TOUCH_RESET];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Event sender: bursts of random length, random gaps between them
  // --------------------------------------------------------------------------
  task automatic send_event(i2csrb_pkg::cmd_e cmd, logic [7:0] b);
    int gap;
    if (!steady_tx && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        ev_if.valid = 1'b0;
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk_i);
    ev_if.valid     = 1'b1;
    ev_if.command   = cmd;
    ev_if.data_byte = b;
    do @(posedge clk_i); while (!ev_if.ready);
    pending_replies.push_back(bus_event_outcome(cmd, b));
    sent_cnt++;
  endtask

  // Sender pauses until every predicted result has been transferred
  task automatic wait_idle();
    @(negedge clk_i);
    ev_if.valid = 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // ID register write, only with the bank idle
  task automatic write_id(logic [7:0] v);
    wait_idle();
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.data  = v;
    do @(posedge clk_i); while (!cfg_if.ready);
    bank_regs[i2csrb_pkg::ADDR_ID] = v;
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // Mostly in-bank selections, some beyond the bank, some below the base
  function automatic logic [7:0] pick_pointer();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 8) return PTR_BASE + 8'($urandom_range(0, NUM_REGS - 1));
    if (sel == 8) return PTR_BASE + 8'($urandom_range(NUM_REGS, 127));
    return 8'($urandom_range(0, 127));
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: ready pattern redrawn at random from four modes; long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : rx_side
    int cyc;
    int mode;
    int held;
    res_if.ready = 1'b0;
    cyc          = 0;
    mode         = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        for (held = 0; held < RX_HOLD_CYCLES; held++) begin
          res_if.ready = 1'b0;
          @(negedge clk_i);
        end
        hold_req = 1'b0;
      end
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      cyc++;
      case (mode)
        0:       res_if.ready = 1'b1;                         // never stalls
        1:       res_if.ready = ($urandom_range(0, 3) != 0);
        2:       res_if.ready = ($urandom_range(0, 9) < 3);
        default: res_if.ready = (cyc % 8 == 0);               // one in eight
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Result checker, sampled at the rising edge
  // --------------------------------------------------------------------------
  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_replies.size() == 0) begin
        $error("result transfer with no prediction outstanding");
        fail_cnt++;
      end else begin
        oldest_reply = pending_replies.pop_front();
        check_field("read_valid", 8'(oldest_reply.read_valid), 8'(res_if.read_valid));
        check_field("read_byte", oldest_reply.read_byte, res_if.read_byte);
        check_field("action", 8'(oldest_reply.action), 8'(res_if.action));
        check_field("action_value", oldest_reply.action_value, res_if.action_value);
        check_field("power_level", oldest_reply.power_level, res_if.power_level);
        check_field("pwm_level", oldest_reply.pwm_level, res_if.pwm_level);
        check_field("lcd_reset_level", oldest_reply.lcd_reset_level,
                    res_if.lcd_reset_level);
        check_field("touch_reset_level", oldest_reply.touch_reset_level,
                    res_if.touch_reset_level);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Buffer reads as zero out of reset; ID holds its default
  task automatic test_reset_state();
    send_event(i2csrb_pkg::CMD_READ, 8'h00);
    send_event(i2csrb_pkg::CMD_READ, 8'hFF);
    send_event(i2csrb_pkg::CMD_START_STOP, 8'h00);
    send_event(i2csrb_pkg::CMD_RX_BYTE, PTR_BASE + 8'(i2csrb_pkg::ADDR_ID));
    send_event(i2csrb_pkg::CMD_READ, 8'h00);
  endtask

  // Register map walk: every side effect, read-only and unselected writes
  task automatic test_register_map();
    send_event(i2csrb_pkg::CMD_START_STOP, 8'h00);
    send_event(i2csrb_pkg::CMD_RX_BYTE, PTR_BASE + 8'(i2csrb_pkg::ADDR_POWER));
    send_event(i2csrb_pkg::CMD_RX_BYTE, 8'hFF);           // power, mirrored to port-B
    send_event(i2csrb_pkg::CMD_START_STOP, 8'h00);
    send_event(i2csrb_pkg::CMD_START_STOP, 8'h00);
    send_event(i2csrb_pkg::CMD_RX_BYTE, PTR_BASE + 8'(i2csrb_pkg::ADDR_PORT_MIRROR));
    send_event(i2csrb_pkg::CMD_READ, 8'h00);
    send_event(i2csrb_pkg::CMD_RX_BYTE, 8'h00);           // port-B is read-only
    send_event(i2csrb_pkg::CMD_START_STOP, 8'h00);
    send_event(i2csrb_pkg::CMD_RX_BYTE, PTR_BASE + 8'(i2csrb_pkg::ADDR_PWM));
    send_event(i2csrb_pkg::CMD_RX_BYTE, 8'h00);           // pwm stopped
    // third byte re-selects
    send_event(i2csrb_pkg::CMD_RX_BYTE, PTR_BASE + 8'(i2csrb_pkg::ADDR_LCD_RESET));
    send_event(i2csrb_pkg::CMD_RX_BYTE, 8'hA5);
    send_event(i2csrb_pkg::CMD_START_STOP, 8'h00);
    send_event(i2csrb_pkg::CMD_RX_BYTE, PTR_BASE + 8'(i2csrb_pkg::ADDR_TOUCH_RESET));
    send_event(i2csrb_pkg::CMD_RX_BYTE, 8'h5A);
    send_event(i2csrb_pkg::CMD_START_STOP, 8'h00);
    // stale buffer byte
    send_event(i2csrb_pkg::CMD_RX_BYTE, PTR_BASE + 8'(i2csrb_pkg::ADDR_TOUCH_XY));
    send_event(i2csrb_pkg::CMD_READ, 8'h00);
    send_event(i2csrb_pkg::CMD_RX_BYTE, 8'h11);           // touch point read-only
    send_event(i2csrb_pkg::CMD_START_STOP, 8'h00);
    send_event(i2csrb_pkg::CMD_RX_BYTE, PTR_BASE + 8'(NUM_REGS));  // beyond the bank
    send_event(i2csrb_pkg::CMD_RX_BYTE, 8'h33);           // nothing selected
    send_event(i2csrb_pkg::CMD_RX_BYTE, 8'h00);           // below base, still none
    send_event(i2csrb_pkg::CMD_NACK, 8'hFF);
    send_event(i2csrb_pkg::CMD_READ, 8'h00);
  endtask

  // ID reprogramming at both extremes, each read back through a selection
  task automatic test_id_config();
    write_id(8'h00);
    send_event(i2csrb_pkg::CMD_START_STOP, 8'h00);
    send_event(i2csrb_pkg::CMD_RX_BYTE, PTR_BASE + 8'(i2csrb_pkg::ADDR_ID));
    send_event(i2csrb_pkg::CMD_READ, 8'h00);
    send_event(i2csrb_pkg::CMD_START_STOP, 8'h00);
    write_id(8'hFF);
    send_event(i2csrb_pkg::CMD_START_STOP, 8'h00);
    send_event(i2csrb_pkg::CMD_RX_BYTE, 8'hFF);           // pointer byte 0xFF
    send_event(i2csrb_pkg::CMD_START_STOP, 8'h00);
    send_event(i2csrb_pkg::CMD_RX_BYTE, PTR_BASE + 8'(i2csrb_pkg::ADDR_ID));
    send_event(i2csrb_pkg::CMD_READ, 8'h00);
    send_event(i2csrb_pkg::CMD_START_STOP, 8'h00);
  endtask

  // Read index wraps past the end of the buffer; a low pointer byte rewinds
  task automatic test_read_wrap();
    send_event(i2csrb_pkg::CMD_START_STOP, 8'h00);
    send_event(i2csrb_pkg::CMD_RX_BYTE, PTR_BASE + 8'(i2csrb_pkg::ADDR_POWER));
    send_event(i2csrb_pkg::CMD_START_STOP, 8'h00);
    repeat (TX_DEPTH + 3) send_event(i2csrb_pkg::CMD_READ, 8'($urandom_range(0, 255)));
    send_event(i2csrb_pkg::CMD_START_STOP, 8'h00);
    send_event(i2csrb_pkg::CMD_RX_BYTE, 8'h05);
    send_event(i2csrb_pkg::CMD_READ, 8'h00);
    send_event(i2csrb_pkg::CMD_START_STOP, 8'h00);
  endtask

  // Receiver holds off while events keep coming, so the block stalls input
  task automatic test_backpressure();
    wait_idle();
    hold_req  = 1'b1;
    steady_tx = 1'b1;
    send_event(i2csrb_pkg::CMD_START_STOP, 8'h00);
    send_event(i2csrb_pkg::CMD_RX_BYTE, PTR_BASE + 8'(i2csrb_pkg::ADDR_PWM));
    repeat (6) begin
      send_event(i2csrb_pkg::CMD_RX_BYTE, 8'($urandom_range(0, 255)));
      send_event(i2csrb_pkg::CMD_READ, 8'h00);
    end
    steady_tx = 1'b0;
    wait_idle();
  endtask

  task automatic random_transfer();
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      // write transfer, sometimes running on into extra bytes
      send_event(i2csrb_pkg::CMD_START_STOP, 8'($urandom_range(0, 255)));
      send_event(i2csrb_pkg::CMD_RX_BYTE, pick_pointer());
      send_event(i2csrb_pkg::CMD_RX_BYTE, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 4) == 0) begin
        send_event(i2csrb_pkg::CMD_RX_BYTE, pick_pointer());
        if ($urandom_range(0, 1) == 0)
          send_event(i2csrb_pkg::CMD_RX_BYTE, 8'($urandom_range(0, 255)));
      end
      send_event(i2csrb_pkg::CMD_START_STOP, 8'($urandom_range(0, 255)));
    end else if (kind < 75) begin
      // pointer set, then a repeated start and a run of reads
      send_event(i2csrb_pkg::CMD_START_STOP, 8'($urandom_range(0, 255)));
      send_event(i2csrb_pkg::CMD_RX_BYTE, pick_pointer());
      send_event(i2csrb_pkg::CMD_START_STOP, 8'($urandom_range(0, 255)));
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(TX_DEPTH - 2, TX_DEPTH + 8)
                                      : $urandom_range(1, 6);
      repeat (n) send_event(i2csrb_pkg::CMD_READ, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) == 0)
        send_event(i2csrb_pkg::CMD_NACK, 8'($urandom_range(0, 255)));
      send_event(i2csrb_pkg::CMD_START_STOP, 8'($urandom_range(0, 255)));
    end else begin
      // noise
      repeat ($urandom_range(1, 4))
        send_event(i2csrb_pkg::cmd_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    end
  endtask

  // Phases of random traffic, a new ID and sender mode in each
  task automatic test_random_traffic();
    int ph;
    int target;
    for (ph = 0; ph < 6; ph++) begin
      write_id(8'($urandom_range(0, 255)));
      steady_tx = (ph % 3 == 1);
      target    = sent_cnt + 90;
      while (sent_cnt < target) random_transfer();
    end
    steady_tx = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int k;
    rst_ni          = 1'b0;
    ev_if.valid     = 1'b0;
    ev_if.command   = i2csrb_pkg::CMD_NACK;
    ev_if.data_byte = 8'h00;
    cfg_if.valid    = 1'b0;
    cfg_if.data     = 8'h00;
    hold_req        = 1'b0;
    steady_tx       = 1'b0;
    burst_left      = 0;
    fail_cnt        = 0;
    sent_cnt        = 0;
    // model state out of reset
    for (k = 0; k < NUM_REGS; k++) bank_regs[k] = 8'h00;
    for (k = 0; k < TX_DEPTH; k++) tx_buf[k] = 8'h00;
    bank_regs[i2csrb_pkg::ADDR_ID] = i2csrb_pkg::ID_DEFAULT;
    sel_ptr           = 5'(NUM_REGS);
    rx_count          = i2csrb_pkg::RX_NONE;
    last_ptr_byte     = 8'h00;
    tx_idx            = 0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_register_map();
    test_id_config();
    test_read_wrap();
    test_backpressure();
    test_random_traffic();

    wait_idle();
    repeat (4) @(posedge clk_i);
    if (fail_cnt == 0 && pending_replies.size() == 0) begin
      $display("** i2c_slave_register_bank: PASSED **");
    end else begin
      $display("** i2c_slave_register_bank: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #400_000;
    $display("** i2c_slave_register_bank: FAILED **");
    $finish;
  end

endmodule
